FILE: rtl/core/clx_pkg.sv
// Shared types and constants for the character stream lexer.
`default_nettype none

package clx_pkg;

    localparam int TEXT_BYTES = 8;
    localparam int TEXT_W     = TEXT_BYTES * 8;
    localparam int LEN_W      = 8;
    localparam int CLASS_W    = 3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CLASS_W-1:0] CLS_KEYWORD = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_IDENT   = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_OPER    = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_DELIM   = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_LITERAL = 3'd4;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_HASH    = 8'd35;
    localparam logic [7:0] CH_PERCENT = 8'd37;
    localparam logic [7:0] CH_LPAREN  = 8'd40;
    localparam logic [7:0] CH_RPAREN  = 8'd41;
    localparam logic [7:0] CH_STAR    = 8'd42;
    localparam logic [7:0] CH_PLUS    = 8'd43;
    localparam logic [7:0] CH_COMMA   = 8'd44;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_SLASH   = 8'd47;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_SEMI    = 8'd59;
    localparam logic [7:0] CH_EQUAL   = 8'd61;

    localparam logic [LEN_W-1:0] LEN_MAX = 8'd255;

    // Keyword text, first byte in the lowest byte, zero padded
    localparam logic [TEXT_W-1:0] KW_DEF_TEXT    = 64'h0000_0000_0066_6564;
    localparam logic [TEXT_W-1:0] KW_RETURN_TEXT = 64'h0000_6e72_7574_6572;
    localparam logic [TEXT_W-1:0] KW_PRINT_TEXT  = 64'h0000_0074_6e69_7270;
    localparam logic [LEN_W-1:0]  KW_DEF_LEN     = 8'd3;
    localparam logic [LEN_W-1:0]  KW_RETURN_LEN  = 8'd6;
    localparam logic [LEN_W-1:0]  KW_PRINT_LEN   = 8'd5;

    typedef struct packed {
        logic [CLASS_W-1:0] token_class;
        logic [TEXT_W-1:0]  token_text;
        logic [LEN_W-1:0]   token_length;
        logic               truncated;
        logic               last_of_run;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } scan_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/char_stream_lexer.sv
// Top level of the character stream lexer: input register, scanner and token queue.
// Takes one source byte per transfer and sustains one byte per cycle. Each byte is held
// in the input register, then goes through the scanner into the token queue, whose head
// drives the output. A byte that ends a pending word and is itself an operator or
// delimiter yields two tokens; the queue takes both at once and drains one per cycle
// while the output is ready, so the input stalls only while the four-entry queue holds
// more than two tokens. Bytes inside a '#' comment and word bytes give no token;
// end_of_input on a byte flushes the pending word after that byte.
`default_nettype none

module char_stream_lexer #(
    parameter int MAX_TOKEN_BYTES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,   // end_of_input
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // [63:0] token_text, [71:64] token_length
    output logic [3:0]       m_axis_tuser,   // [2:0] token_class, [3] truncated
    output logic             m_axis_tlast    // last_of_run
);
    import clx_pkg::*;

    logic       in_vld_reg;
    logic [7:0] in_char_reg;
    logic       in_eoi_reg;
    logic       room;
    logic       go;
    logic       in_xfer;
    scan_res_t  res;
    token_t     out_tok;

    assign go            = in_vld_reg && room;
    assign s_axis_tready = !in_vld_reg || go;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (go)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_char_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tlast;
        end
    end

    clx_scan #(
        .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (go),
        .char_code    (in_char_reg),
        .end_of_input (in_eoi_reg),
        .res          (res)
    );

    clx_tok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (go),
        .in_res    (res),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tok   (out_tok)
    );

    assign m_axis_tdata = {out_tok.token_length, out_tok.token_text};
    assign m_axis_tuser = {out_tok.truncated, out_tok.token_class};
    assign m_axis_tlast = out_tok.last_of_run;

endmodule

`default_nettype wire

FILE: rtl/core/clx_scan.sv
// Byte classifier, pending word state and token builder.
`default_nettype none

module clx_scan #(
    parameter int MAX_TOKEN_BYTES = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               go,
    input  wire logic [7:0]         char_code,
    input  wire logic               end_of_input,
    output clx_pkg::scan_res_t      res
);
    import clx_pkg::*;

    localparam logic [LEN_W-1:0] STORE_LEN = LEN_W'(MAX_TOKEN_BYTES);

    logic [TEXT_W-1:0] word_bytes_reg, word_bytes_next;
    logic [LEN_W-1:0]  word_length_reg, word_length_next;
    logic              in_comment_reg, in_comment_next;

    logic              is_ws, is_hash, is_op, is_delim, is_nl;
    logic              flush_now, append, single_vld, word_vld;
    logic [TEXT_W-1:0] src_bytes;
    logic [LEN_W-1:0]  src_length;
    logic              is_kw;
    token_t            word_tok, single_tok;

    always_comb
    begin
        is_nl    = (char_code == CH_NL);
        is_ws    = char_code inside {CH_SPACE, CH_TAB, CH_NL};
        is_hash  = (char_code == CH_HASH);
        is_op    = char_code inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT,
                                     CH_EQUAL};
        is_delim = char_code inside {CH_COMMA, CH_SEMI, CH_LPAREN, CH_RPAREN};

        flush_now  = in_comment_reg ? is_nl : (is_ws || is_op || is_delim);
        single_vld = !in_comment_reg && (is_op || is_delim);
        append     = !in_comment_reg && !is_hash && !is_ws && !is_op && !is_delim;

        // append the byte into the next free lane while lanes remain
        src_bytes  = word_bytes_reg;
        src_length = word_length_reg;
        if (append)
        begin
            for (int i = 0; i < TEXT_BYTES; i++)
            begin
                if ((i < MAX_TOKEN_BYTES) && (word_length_reg == LEN_W'(i)))
                begin
                    src_bytes[i*8 +: 8] = char_code;
                end
            end
            if (word_length_reg != LEN_MAX)
            begin
                src_length = word_length_reg + 8'd1;
            end
        end

        word_vld = (flush_now || end_of_input) && (src_length != '0);

        is_kw = ((src_length == KW_DEF_LEN)    && (src_bytes == KW_DEF_TEXT))
             || ((src_length == KW_RETURN_LEN) && (src_bytes == KW_RETURN_TEXT))
             || ((src_length == KW_PRINT_LEN)  && (src_bytes == KW_PRINT_TEXT));

        word_tok.token_text   = src_bytes;
        word_tok.token_length = src_length;
        word_tok.truncated    = (src_length > STORE_LEN);
        word_tok.last_of_run  = !single_vld;
        if (is_kw)
        begin
            word_tok.token_class = CLS_KEYWORD;
        end
        else if ((src_bytes[7:0] >= CH_ZERO) && (src_bytes[7:0] <= CH_NINE))
        begin
            word_tok.token_class = CLS_LITERAL;
        end
        else
        begin
            word_tok.token_class = CLS_IDENT;
        end

        single_tok.token_class  = is_op ? CLS_OPER : CLS_DELIM;
        single_tok.token_text   = {{(TEXT_W-8){1'b0}}, char_code};
        single_tok.token_length = 8'd1;
        single_tok.truncated    = 1'b0;
        single_tok.last_of_run  = 1'b1;

        res.count = 2'(word_vld) + 2'(single_vld);
        res.tok0  = word_vld ? word_tok : single_tok;
        res.tok1  = single_tok;

        if (flush_now || end_of_input)
        begin
            word_bytes_next  = '0;
            word_length_next = '0;
        end
        else
        begin
            word_bytes_next  = src_bytes;
            word_length_next = src_length;
        end

        if (end_of_input)
        begin
            in_comment_next = 1'b0;
        end
        else if (in_comment_reg)
        begin
            in_comment_next = !is_nl;
        end
        else
        begin
            in_comment_next = is_hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_bytes_reg  <= '0;
            word_length_reg <= '0;
            in_comment_reg  <= 1'b0;
        end
        else if (go)
        begin
            word_bytes_reg  <= word_bytes_next;
            word_length_reg <= word_length_next;
            in_comment_reg  <= in_comment_next;
        end
    end

    a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
        go && end_of_input |=> (word_length_reg == '0) && !in_comment_reg)
        else $error("pending word or comment mode survives end of input");

    a_empty_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (word_length_reg == '0) |-> (word_bytes_reg == '0))
        else $error("stale bytes held with no pending word");

    a_two_means_single: assert property (@(posedge clk) disable iff (!rst_n)
        go && (res.count == 2'd2) |-> !res.tok0.last_of_run && res.tok1.last_of_run)
        else $error("two tokens from one byte carry wrong run marks");

endmodule

`default_nettype wire

FILE: rtl/core/clx_tok_fifo.sv
// Output token queue: up to two tokens in per cycle, one out if ready.
`default_nettype none

module clx_tok_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  clx_pkg::scan_res_t in_res,
    output logic               room,
    output logic               out_valid,
    input  wire logic          out_ready,
    output clx_pkg::token_t    out_tok
);
    import clx_pkg::*;

    token_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [1:0]            push_n;
    logic                  pop;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus1;

    always_comb
    begin
        push_n       = push ? in_res.count : 2'd0;
        pop          = out_valid && out_ready;
        wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_W'(1);
        wr_ptr_next  = wr_ptr_reg + FIFO_PTR_W'(push_n);
        rd_ptr_next  = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next   = count_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end

    assign room      = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_tok   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= in_res.tok0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= in_res.tok1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("token queue overfilled");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> room)
        else $error("tokens pushed without room for a full pair");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == FIFO_PTR_W'(count_reg))
        else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for char_stream_lexer: byte stream in, checked token stream out.
`default_nettype none

module testbench;

    import clx_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;

    typedef enum int {
        BK_SPACE,
        BK_HASH,
        BK_OPER,
        BK_DELIM,
        BK_WORD
    } byte_kind_t;

    typedef struct packed {
        logic [7:0] code;
        logic       eoi;
    } src_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    src_byte_t   src_q[$];
    token_t      token_q[$];

    int          n_queued = 0;
    int          n_issued = 0;
    int          n_accepted = 0;
    int          errors = 0;
    int          cycle_cnt = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_req = 0;
    int          hold_ack = 0;
    int          hold_left = 0;

    logic [TEXT_W-1:0] word_text = '0;
    logic [LEN_W-1:0]  word_len = '0;
    logic              in_comment = 1'b0;
    token_t            held_tok;
    logic              held_valid = 1'b0;

    char_stream_lexer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic byte_kind_t byte_kind(logic [7:0] b);
        case (b)
            CH_SPACE, CH_TAB, CH_NL:                            return BK_SPACE;
            CH_HASH:                                            return BK_HASH;
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT,
            CH_EQUAL:                                           return BK_OPER;
            CH_COMMA, CH_SEMI, CH_LPAREN, CH_RPAREN:            return BK_DELIM;
            default:                                            return BK_WORD;
        endcase
    endfunction

    // Delay each token by one so the final token of a byte can be marked.
    function automatic void stage_token(token_t t);
        if (held_valid)
            token_q = {token_q, held_tok};
        held_tok = t;
        held_valid = 1'b1;
    endfunction

    function automatic void flush_word();
        token_t t;
        if (word_len != 0)
        begin
            if ((word_len == KW_DEF_LEN && word_text == KW_DEF_TEXT) ||
                (word_len == KW_RETURN_LEN && word_text == KW_RETURN_TEXT) ||
                (word_len == KW_PRINT_LEN && word_text == KW_PRINT_TEXT))
                t.token_class = CLS_KEYWORD;
            else if (word_text[7:0] >= CH_ZERO && word_text[7:0] <= CH_NINE)
                t.token_class = CLS_LITERAL;
            else
                t.token_class = CLS_IDENT;
            t.token_text = word_text;
            t.token_length = word_len;
            t.truncated = (word_len > TEXT_BYTES);
            t.last_of_run = 1'b0;
            stage_token(t);
            word_text = '0;
            word_len = '0;
        end
    endfunction

    function automatic void lex_byte(logic [7:0] code, logic eoi);
        token_t t;
        if (in_comment)
        begin
            if (code == CH_NL)
            begin
                in_comment = 1'b0;
                flush_word();
            end
        end
        else
        begin
            case (byte_kind(code))
                BK_HASH:  in_comment = 1'b1;
                BK_SPACE: flush_word();
                BK_OPER, BK_DELIM:
                begin
                    flush_word();
                    t.token_class = (byte_kind(code) == BK_OPER) ? CLS_OPER : CLS_DELIM;
                    t.token_text = {{(TEXT_W-8){1'b0}}, code};
                    t.token_length = 8'd1;
                    t.truncated = 1'b0;
                    t.last_of_run = 1'b0;
                    stage_token(t);
                end
                default:
                begin
                    if (word_len < TEXT_BYTES)
                        word_text[word_len*8 +: 8] = code;
                    if (word_len != LEN_MAX)
                        word_len = word_len + 1'b1;
                end
            endcase
        end
        if (eoi)
        begin
            flush_word();
            in_comment = 1'b0;
        end
        if (held_valid)
        begin
            held_tok.last_of_run = 1'b1;
            token_q = {token_q, held_tok};
            held_valid = 1'b0;
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        token_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                lex_byte(s_axis_tdata, s_axis_tlast);
                n_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (token_q.size() == 0)
                begin
                    $display("%0t: unexpected token, expected none, actual %0h", $time,
                             {m_axis_tuser, m_axis_tdata, m_axis_tlast});
                    errors++;
                end
                else
                begin
                    want = token_q.pop_front();
                    check_field("token_class", 64'(want.token_class),
                                64'(m_axis_tuser[2:0]));
                    check_field("token_text", want.token_text, m_axis_tdata[63:0]);
                    check_field("token_length", 64'(want.token_length),
                                64'(m_axis_tdata[71:64]));
                    check_field("truncated", 64'(want.truncated), 64'(m_axis_tuser[3]));
                    check_field("last_of_run", 64'(want.last_of_run), 64'(m_axis_tlast));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        src_byte_t it;
        if (!s_axis_tvalid || n_accepted == n_issued)
        begin
            if (rst_n && src_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = src_q.pop_front();
                s_axis_tdata <= it.code;
                s_axis_tlast <= it.eoi;
                s_axis_tvalid <= 1'b1;
                n_issued++;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Hold off the output for a long stretch when requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_req != hold_ack)
        begin
            hold_left <= LONG_HOLD;
            hold_ack <= hold_req;
        end
        m_axis_tready <= (hold_left == 0) && (hold_req == hold_ack) &&
                         ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic add_byte(logic [7:0] b, logic eoi);
        src_byte_t it;
        it.code = b;
        it.eoi = eoi;
        src_q = {src_q, it};
        n_queued++;
    endtask

    task automatic add_text(string s, logic eoi_at_end);
        int i;
        for (i = 0; i < s.len(); i++)
            add_byte(s[i], eoi_at_end && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] rand_of_kind(byte_kind_t k);
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (byte_kind(b) != k);
        return b;
    endfunction

    task automatic add_random_chunk();
        string kw[3];
        int    len;
        int    i;
        kw[0] = "def";
        kw[1] = "return";
        kw[2] = "print";
        case ($urandom_range(9))
            0:
            begin
                add_text(kw[$urandom_range(2)], $urandom_range(39) == 0);
                if ($urandom_range(3) == 0)
                    add_byte(rand_of_kind(BK_WORD), 1'b0);
            end
            1, 2:
            begin
                add_byte(8'(8'h61 + $urandom_range(25)), 1'b0);
                len = $urandom_range(10);
                for (i = 0; i < len; i++)
                    add_byte(8'(8'h61 + $urandom_range(25)), $urandom_range(39) == 0);
            end
            3:
            begin
                add_byte(8'(CH_ZERO + $urandom_range(9)), 1'b0);
                len = $urandom_range(9);
                for (i = 0; i < len; i++)
                    add_byte(rand_of_kind(BK_WORD), $urandom_range(39) == 0);
            end
            4: add_byte(rand_of_kind($urandom_range(1) ? BK_OPER : BK_DELIM),
                        $urandom_range(39) == 0);
            5: add_byte(rand_of_kind(BK_SPACE), $urandom_range(39) == 0);
            6:
            begin
                add_byte(CH_HASH, 1'b0);
                len = $urandom_range(6);
                for (i = 0; i < len; i++)
                    add_byte(8'($urandom_range(255)), $urandom_range(39) == 0);
                add_byte(CH_NL, 1'b0);
            end
            7: add_byte(8'($urandom_range(255)), $urandom_range(39) == 0);
            default:
            begin
                len = $urandom_range(1, 12);
                for (i = 0; i < len; i++)
                    add_byte(rand_of_kind(BK_WORD), $urandom_range(39) == 0);
            end
        endcase
    endtask

    task automatic add_random_text(int count);
        int stop_at;
        stop_at = n_queued + count;
        while (n_queued < stop_at)
            add_random_chunk();
    endtask

    task automatic drain();
        while (src_q.size() != 0 || n_accepted != n_issued || token_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int ph;
        int i;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 85;
        add_text("def(a,b)", 1'b0);
        add_text("9x#c\n", 1'b0);
        add_text("+-*/%=;", 1'b0);
        add_byte(8'd0, 1'b0);
        add_byte(8'd255, 1'b1);
        add_text("#z", 1'b1);
        drain();

        for (ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 85 : 0;
            recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 35 : 0;
            if (ph == 2)
                hold_req++;
            add_random_text(250);
            if (ph == 0)
            begin
                add_byte(8'h77, 1'b0);
                for (i = 0; i < 261; i++)
                    add_byte(rand_of_kind(BK_WORD), 1'b0);
                add_byte(CH_SPACE, 1'b0);
            end
            drain();
        end

        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/clx_pkg.sv
rtl/core/clx_scan.sv
rtl/core/clx_tok_fifo.sv
rtl/core/char_stream_lexer.sv
verif/testbench.sv
